@@ hdl/sspq_pkg.sv @@
// sspq_pkg: shared types, sizes and codes for the sorted priority queue unit
// used by the controller, datapath, top level and checker; no dependencies
`timescale 1ns / 1ps

package sspq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 32;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     action;
    logic [PRIORITY_BITS-1:0] task_priority;
    logic [PAYLOAD_BITS-1:0]  task_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] popped_priority;
    logic [PAYLOAD_BITS-1:0]  popped_payload;
    logic                     queue_empty;
    logic [COUNT_BITS-1:0]    entry_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the accepted input item
    logic exec;  // apply the operation and fill the result register
  } ctl_cmd_t;

endpackage

@@ hdl/sspq_ctrl.sv @@
// sspq_ctrl: controller state machine and result-channel handshake
// depends on sspq_pkg
`timescale 1ns / 1ps

module sspq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output sspq_pkg::ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load = in_valid && !in_stall;
    // result register is free or being emptied this cycle
    cmd.exec = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/sspq_dpath.sv @@
// sspq_dpath: sorted slot shift register, fill count and result register
// depends on sspq_pkg
`timescale 1ns / 1ps

module sspq_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  sspq_pkg::ctl_cmd_t  cmd,
  input  sspq_pkg::in_item_t  in_item,
  output sspq_pkg::out_item_t out_item
);

  localparam int CAP = sspq_pkg::CAPACITY;
  localparam int PB  = sspq_pkg::PRIORITY_BITS;
  localparam int DB  = sspq_pkg::PAYLOAD_BITS;
  localparam int CB  = sspq_pkg::COUNT_BITS;

  sspq_pkg::in_item_t  item_r;
  sspq_pkg::out_item_t res_r, res_nxt;

  logic [PB-1:0] slot_prio_r [CAP];
  logic [DB-1:0] slot_data_r [CAP];
  logic [PB-1:0] slot_prio_nxt [CAP];
  logic [DB-1:0] slot_data_nxt [CAP];
  logic [CB-1:0] count_r, count_nxt;

  logic [CAP-1:0] ge;
  logic           is_full;
  logic           is_empty;
  logic           do_push;
  logic           do_pop;

  assign is_full  = (count_r == CB'(CAP));
  assign is_empty = (count_r == '0);
  assign do_push  = (item_r.action == sspq_pkg::ACT_PUSH) && !is_full;
  assign do_pop   = (item_r.action == sspq_pkg::ACT_POP) && !is_empty;

  // stored slots that stay ahead of the new task; a prefix since slots are sorted
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ge[i] = (CB'(i) < count_r) && (slot_prio_r[i] >= item_r.task_priority);
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_slot
    logic take_new;
    if (g == 0) begin : g_head
      assign take_new = !ge[0];
    end else begin : g_body
      assign take_new = !ge[g] && ge[g-1];
    end

    always_comb begin
      slot_prio_nxt[g] = slot_prio_r[g];
      slot_data_nxt[g] = slot_data_r[g];
      if (do_push && !ge[g]) begin
        if (take_new) begin
          slot_prio_nxt[g] = item_r.task_priority;
          slot_data_nxt[g] = item_r.task_payload;
        end else begin
          if (g > 0) begin
            slot_prio_nxt[g] = slot_prio_r[(g > 0) ? g - 1 : 0];
            slot_data_nxt[g] = slot_data_r[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_pop && (g < CAP - 1)) begin
        slot_prio_nxt[g] = slot_prio_r[(g < CAP - 1) ? g + 1 : g];
        slot_data_nxt[g] = slot_data_r[(g < CAP - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CB'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CB'(1);
    end

    res_nxt.popped_priority = '0;
    res_nxt.popped_payload  = '0;
    if (item_r.action == sspq_pkg::ACT_PUSH) begin
      res_nxt.status = is_full ? sspq_pkg::ST_FULL : sspq_pkg::ST_DONE;
    end else begin
      res_nxt.status = is_empty ? sspq_pkg::ST_EMPTY : sspq_pkg::ST_DONE;
      if (!is_empty) begin
        res_nxt.popped_priority = slot_prio_r[0];
        res_nxt.popped_payload  = slot_data_r[0];
      end
    end
    res_nxt.entry_count = count_nxt;
    res_nxt.queue_empty = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < CAP; i++) begin
        slot_prio_r[i] <= slot_prio_nxt[i];
        slot_data_r[i] <= slot_data_nxt[i];
      end
    end
  end

  assign out_item = res_r;

endmodule

@@ hdl/stable_sorted_priority_queue_unit.sv @@
// stable_sorted_priority_queue_unit: top level of the sorted priority queue
// the result register is written after the item is captured, and waits while an earlier result is stalled
// one parallel compare-and-shift step per item after capture; input stalls until that step is done
// a new item is taken while an earlier result still waits in the output register
// reset (rst_n low, synchronous) empties the queue and the result register;
// slot contents are left as they are
`timescale 1ns / 1ps

module stable_sorted_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sspq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sspq_pkg::out_item_t out_item
);

  sspq_pkg::ctl_cmd_t cmd;

  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sspq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ hdl/sspq_checker.sv @@
// sspq_checker: port-level assertions for the sorted priority queue unit
// depends on sspq_pkg; bound to stable_sorted_priority_queue_unit below
`timescale 1ns / 1ps

module sspq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sspq_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input sspq_pkg::out_item_t out_item
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.queue_empty == (out_item.entry_count == '0)) &&
                  (out_item.entry_count <= sspq_pkg::COUNT_BITS'(sspq_pkg::CAPACITY)))
    else $error("empty flag or count inconsistent");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == sspq_pkg::ST_FULL) |->
      (out_item.entry_count == sspq_pkg::COUNT_BITS'(sspq_pkg::CAPACITY)) &&
      (out_item.popped_priority == '0) && (out_item.popped_payload == '0))
    else $error("dropped push with queue not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == sspq_pkg::ST_EMPTY) |->
      (out_item.entry_count == '0) &&
      (out_item.popped_priority == '0) && (out_item.popped_payload == '0))
    else $error("empty pop with queue not empty");

  // one item in flight: an input transfer closes the input side next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first was done");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (.*);

@@ tb/tb_stable_sorted_priority_queue_unit.sv @@
// tb_stable_sorted_priority_queue_unit: self-checking bench for the sorted priority queue
// keeps a shadow copy of the sorted slots and checks every result transfer field by field
// depends on sspq_pkg and stable_sorted_priority_queue_unit
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue_unit;
  import sspq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int send_idle_pct = 21;
  int recv_idle_pct = 57;
  int error_count = 0;

  // shadow of the queue contents, slot 0 leaves next
  logic [PRIORITY_BITS-1:0] shadow_prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  shadow_payload [CAPACITY];
  int                       shadow_count = 0;

  out_item_t expected_results [$];

  stable_sorted_priority_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    // keep the log short when the block is badly broken
    if (error_count < 100) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    end
    error_count++;
  endtask

  // applies one item to the shadow queue and returns the result it should give
  function automatic out_item_t predict_queue_step(input in_item_t it);
    out_item_t r;
    int        pos;
    int        i;
    r = '0;
    r.status = ST_DONE;
    if (it.action == ACT_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // stable insert: go past every task of equal or higher priority
        while (pos < shadow_count && shadow_prio[pos] >= it.task_priority) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_prio[i]    = shadow_prio[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_prio[pos]    = it.task_priority;
        shadow_payload[pos] = it.task_payload;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_priority = shadow_prio[0];
        r.popped_payload  = shadow_payload[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1]    = shadow_prio[i];
          shadow_payload[i-1] = shadow_payload[i];
        end
        shadow_count--;
      end
    end
    r.queue_empty = (shadow_count == 0);
    r.entry_count = COUNT_BITS'(shadow_count);
    return r;
  endfunction

  // called right after a rising edge; returns right after the edge that took the item
  task automatic send_request(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_results.push_back(predict_queue_step(it));
  endtask

  function automatic in_item_t make_item(input logic act, input logic [PRIORITY_BITS-1:0] prio,
                                         input logic [PAYLOAD_BITS-1:0] data);
    in_item_t it;
    it.action        = act;
    it.task_priority = prio;
    it.task_payload  = data;
    return it;
  endfunction

  // pops on an empty queue, with extreme and zero task fields that must be ignored
  task automatic test_pop_empty();
    send_request(make_item(ACT_POP, '1, '1));
    send_request(make_item(ACT_POP, '0, '0));
  endtask

  // fills every slot with extremes and repeated priorities
  task automatic test_fill_to_capacity();
    logic [PRIORITY_BITS-1:0] prios [16] = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h01,
                                             8'hFE, 8'h80, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h40,
                                             8'hC0, 8'h80};
    logic [PAYLOAD_BITS-1:0]  data;
    for (int i = 0; i < CAPACITY; i++) begin
      data = (i == 0) ? '0 : (i == 1) ? '1 : 32'hC0DE_0000 + i;
      send_request(make_item(ACT_PUSH, prios[i % 16], data));
    end
  endtask

  // pushes into a full queue are dropped, even at top priority
  task automatic test_push_when_full();
    send_request(make_item(ACT_PUSH, '1, 32'h5A5A_A5A5));
    send_request(make_item(ACT_PUSH, '0, 32'hA5A5_5A5A));
  endtask

  // top-priority tasks must come out in arrival order
  task automatic test_drain_in_order();
    repeat (5) send_request(make_item(ACT_POP, 8'h3C, 32'hDEAD_BEEF));
  endtask

  // bursts that lean toward filling or draining or stay balanced, with tie-heavy priorities
  task automatic test_random_traffic(input int n_items);
    in_item_t it;
    int       push_pct;
    int       burst;
    int       sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      burst = $urandom_range(4, 40);
      while (burst > 0 && sent < n_items) begin
        it.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        case ($urandom_range(0, 3))
          0: it.task_priority = PRIORITY_BITS'($urandom_range(0, 3));
          1: it.task_priority = $urandom_range(0, 1) ? '1 : '0;
          default: it.task_priority = PRIORITY_BITS'($urandom);
        endcase
        it.task_payload = PAYLOAD_BITS'($urandom);
        send_request(it);
        burst--;
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", '0, out_item.popped_payload);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", want.status, out_item.status);
        if (out_item.popped_priority !== want.popped_priority)
          report_mismatch("popped_priority", want.popped_priority, out_item.popped_priority);
        if (out_item.popped_payload !== want.popped_payload)
          report_mismatch("popped_payload", want.popped_payload, out_item.popped_payload);
        if (out_item.queue_empty !== want.queue_empty)
          report_mismatch("queue_empty", want.queue_empty, out_item.queue_empty);
        if (out_item.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_item.entry_count);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_empty();
    test_fill_to_capacity();
    test_push_when_full();
    test_drain_in_order();
    test_random_traffic(192);

    send_idle_pct = 57;
    recv_idle_pct = 21;
    test_random_traffic(192);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(191);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
